>>> rtl/two_level_sorted_word_lookup_macros.svh
// Assertion macros shared by the checkers of this block.
`ifndef TWO_LEVEL_SORTED_WORD_LOOKUP_MACROS_SVH
`define TWO_LEVEL_SORTED_WORD_LOOKUP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TLSWL_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TLSWL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/tlswl_pkg.sv
`timescale 1ns / 1ps
package tlswl_pkg;
  localparam int MAX_WORD       = 16;
  localparam int TAIL_BYTES     = MAX_WORD - 2;
  localparam int TAIL_W         = 8 * TAIL_BYTES;
  localparam int HEAD_W         = 16;
  localparam int END_W          = 13;
  localparam int HENT_W         = HEAD_W + END_W;
  localparam int HCNT_W         = 10;
  localparam int LEN_W          = 5;
  localparam int OP_W           = 3;
  localparam int IDX_W          = 12;
  localparam int SKIP_W         = 5;
  localparam int HEAD_DEPTH_DEF = 676;
  localparam int TAIL_DEPTH_DEF = 4096;

  localparam logic [OP_W-1:0] OP_WHEAD  = 3'd0;
  localparam logic [OP_W-1:0] OP_WTAIL  = 3'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP = 3'd2;
  localparam logic [OP_W-1:0] OP_START  = 3'd3;
  localparam logic [OP_W-1:0] OP_NEXT   = 3'd4;
  localparam logic [OP_W-1:0] OP_SKIP   = 3'd5;

  localparam logic REG_WORD_LENGTH = 1'b0;
  localparam logic REG_HEAD_COUNT  = 1'b1;

  typedef enum logic [4:0] {
    DP_NONE, DP_LATCH, DP_WHEAD, DP_WTAIL, DP_START, DP_SKIP, DP_DONE,
    DP_HPROBE, DP_HSTEP, DP_HHIT, DP_BPROBE, DP_BLOAD, DP_TPROBE, DP_TSTEP,
    DP_FOUND, DP_SHPROBE, DP_SHLOAD, DP_STPROBE, DP_SEMIT, DP_OLOAD
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] opcode;
    logic            h_live;
    logic            h_eq;
    logic            k_zero;
    logic            len2_zero;
    logic            t_live;
    logic            t_eq;
    logic            need_head;
    logic            heads_left;
    logic            out_free;
  } stat_t;

  // Tail bytes below len2 placed first byte most significant, so that a plain
  // unsigned compare orders tails the way bytewise comparison does.
  function automatic logic [TAIL_W-1:0] tail_key(input logic [TAIL_W-1:0] tail,
                                                 input logic [LEN_W-1:0] len2);
    logic [TAIL_W-1:0] key;
    key = '0;
    for (int t = 0; t < TAIL_BYTES; t++) begin
      if (t < int'(len2)) key[(TAIL_BYTES-1-t)*8 +: 8] = tail[t*8 +: 8];
    end
    return key;
  endfunction

  // Tail bytes below len2 kept in place, the rest zeroed.
  function automatic logic [TAIL_W-1:0] tail_mask(input logic [TAIL_W-1:0] tail,
                                                  input logic [LEN_W-1:0] len2);
    logic [TAIL_W-1:0] res;
    res = '0;
    for (int t = 0; t < TAIL_BYTES; t++) begin
      if (t < int'(len2)) res[t*8 +: 8] = tail[t*8 +: 8];
    end
    return res;
  endfunction
endpackage

>>> rtl/tlswl_if.sv
`timescale 1ns / 1ps
interface tlswl_in_if;
  import tlswl_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [IDX_W-1:0]  entry_index;
  logic [HEAD_W-1:0] head_letters;
  logic [END_W-1:0]  block_end;
  logic [63:0]       word_low;
  logic [63:0]       word_high;
  logic [SKIP_W-1:0] skip_count;
  modport source(output valid, opcode, entry_index, head_letters, block_end, word_low,
                 word_high, skip_count, input ready);
  modport sink(input valid, opcode, entry_index, head_letters, block_end, word_low,
               word_high, skip_count, output ready);
endinterface

interface tlswl_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [63:0] out_word_low;
  logic [63:0] out_word_high;
  logic        scan_done;
  modport source(output valid, found, out_word_low, out_word_high, scan_done,
                 input ready);
  modport sink(input valid, found, out_word_low, out_word_high, scan_done,
               output ready);
endinterface

>>> rtl/tlswl_ram.sv
`timescale 1ns / 1ps
module tlswl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;
endmodule

>>> rtl/tlswl_dp.sv
`timescale 1ns / 1ps
module tlswl_dp #(
  parameter int HEAD_DEPTH = tlswl_pkg::HEAD_DEPTH_DEF,
  parameter int TAIL_DEPTH = tlswl_pkg::TAIL_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tlswl_pkg::cmd_t               cmd,
  output tlswl_pkg::stat_t              stat,
  input  logic [tlswl_pkg::LEN_W-1:0]   eff_len,
  input  logic [tlswl_pkg::HCNT_W-1:0]  eff_heads,
  input  logic [tlswl_pkg::OP_W-1:0]    in_opcode,
  input  logic [tlswl_pkg::IDX_W-1:0]   in_entry_index,
  input  logic [tlswl_pkg::HEAD_W-1:0]  in_head_letters,
  input  logic [tlswl_pkg::END_W-1:0]   in_block_end,
  input  logic [63:0]                   in_word_low,
  input  logic [63:0]                   in_word_high,
  input  logic [tlswl_pkg::SKIP_W-1:0]  in_skip_count,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_found,
  output logic [63:0]                   out_word_low,
  output logic [63:0]                   out_word_high,
  output logic                          out_scan_done
);
  import tlswl_pkg::*;

  localparam int HAW = (HEAD_DEPTH > 1) ? $clog2(HEAD_DEPTH) : 1;
  localparam int TAW = (TAIL_DEPTH > 1) ? $clog2(TAIL_DEPTH) : 1;
  localparam logic [END_W-1:0] CUR_MAX = {END_W{1'b1}};

  logic [OP_W-1:0]   op_r;
  logic [HEAD_W-1:0] key_r;
  logic [TAIL_W-1:0] tkey_r, twr_r;
  logic [IDX_W-1:0]  idx_r;
  logic [HEAD_W-1:0] hl_r;
  logic [END_W-1:0]  be_r;
  logic              skip_small_r;
  logic [HCNT_W-1:0] hi_r, hi_nxt, hj_r, hj_nxt, hk_r, hk_nxt;
  logic [END_W-1:0]  ti_r, ti_nxt, tj_r, tj_nxt, tk_r, tk_nxt;
  logic              tvalid_r, tvalid_nxt;
  logic [HCNT_W-1:0] pos_r, pos_nxt;
  logic [END_W-1:0]  cur_r, cur_nxt, lim_r, lim_nxt;
  logic [HEAD_W-1:0] chead_r, chead_nxt;
  logic              found_r, found_nxt, done_r, done_nxt;
  logic [63:0]       wlo_r, wlo_nxt, whi_r, whi_nxt;
  logic              ov_r, ov_nxt, of_r, od_r;
  logic [63:0]       olo_r, ohi_r;

  logic [LEN_W-1:0]  len2;
  logic [HCNT_W:0]   hsum;
  logic [HCNT_W-1:0] hmid, hk_m1;
  logic [END_W:0]    tsum;
  logic [END_W-1:0]  tmid;
  logic [31:0]       tmid_w, cur_w, idx_w;
  logic              h_we, t_we;
  logic [HAW-1:0]    h_raddr;
  logic [TAW-1:0]    t_raddr;
  logic [HENT_W-1:0] h_rdata;
  logic [TAIL_W-1:0] t_rdata, t_eff, t_key;
  logic [HEAD_W-1:0] hd_head;
  logic [END_W-1:0]  hd_end;
  logic              h_lt, t_lt;
  logic [127:0]      sword;

  assign len2    = eff_len - LEN_W'(2);
  assign hsum    = {1'b0, hi_r} + {1'b0, hj_r};
  assign hmid    = hsum[HCNT_W:1];
  assign hk_m1   = hk_r - HCNT_W'(1);
  assign tsum    = {1'b0, ti_r} + {1'b0, tj_r};
  assign tmid    = tsum[END_W:1];
  assign tmid_w  = 32'(tmid);
  assign cur_w   = 32'(cur_r);
  assign idx_w   = 32'(idx_r);
  assign hd_head = h_rdata[HEAD_W-1:0];
  assign hd_end  = h_rdata[HENT_W-1:HEAD_W];
  assign h_lt    = key_r < hd_head;
  // An index past the tail store reads as an all-zero tail.
  assign t_eff   = tvalid_r ? t_rdata : '0;
  assign t_key   = tail_key(t_eff, len2);
  assign t_lt    = tkey_r < t_key;
  assign sword   = {tail_mask(t_eff, len2), chead_r[7:0], chead_r[15:8]};

  assign h_we = (cmd.op == DP_WHEAD) && (idx_w < HEAD_DEPTH);
  assign t_we = (cmd.op == DP_WTAIL) && (idx_w < TAIL_DEPTH);

  always_comb begin
    unique case (cmd.op)
      DP_HPROBE: h_raddr = hmid[HAW-1:0];
      DP_BPROBE: h_raddr = hk_m1[HAW-1:0];
      default:   h_raddr = pos_r[HAW-1:0];
    endcase
    t_raddr = (cmd.op == DP_TPROBE) ? tmid_w[TAW-1:0] : cur_w[TAW-1:0];
  end

  tlswl_ram #(.WIDTH(HENT_W), .DEPTH(HEAD_DEPTH)) u_head_ram (
    .clk(clk), .we(h_we), .waddr(idx_r[HAW-1:0]), .wdata({be_r, hl_r}),
    .raddr(h_raddr), .rdata(h_rdata)
  );

  tlswl_ram #(.WIDTH(TAIL_W), .DEPTH(TAIL_DEPTH)) u_tail_ram (
    .clk(clk), .we(t_we), .waddr(idx_w[TAW-1:0]), .wdata(twr_r),
    .raddr(t_raddr), .rdata(t_rdata)
  );

  always_comb begin
    hi_nxt = hi_r; hj_nxt = hj_r; hk_nxt = hk_r;
    ti_nxt = ti_r; tj_nxt = tj_r; tk_nxt = tk_r; tvalid_nxt = tvalid_r;
    pos_nxt = pos_r; cur_nxt = cur_r; lim_nxt = lim_r; chead_nxt = chead_r;
    found_nxt = found_r; done_nxt = done_r; wlo_nxt = wlo_r; whi_nxt = whi_r;
    ov_nxt = ov_r && !out_ready;
    unique case (cmd.op)
      DP_LATCH: begin
        hi_nxt = '0; hj_nxt = eff_heads;
        found_nxt = 1'b0; done_nxt = 1'b0; wlo_nxt = '0; whi_nxt = '0;
      end
      DP_START: begin
        pos_nxt = '0; cur_nxt = '0; lim_nxt = '0; chead_nxt = '0;
      end
      DP_SKIP: begin
        if (skip_small_r) cur_nxt = lim_r;
      end
      DP_DONE:   done_nxt = 1'b1;
      DP_FOUND:  found_nxt = 1'b1;
      DP_HPROBE: hk_nxt = hmid;
      DP_HSTEP: begin
        if (h_lt) hj_nxt = hk_r;
        else hi_nxt = hk_r + HCNT_W'(1);
      end
      DP_HHIT: begin
        ti_nxt = '0; tj_nxt = hd_end;
      end
      DP_BLOAD: ti_nxt = hd_end;
      DP_TPROBE: begin
        tk_nxt = tmid; tvalid_nxt = tmid_w < TAIL_DEPTH;
      end
      DP_TSTEP: begin
        if (t_lt) tj_nxt = tk_r;
        else ti_nxt = tk_r + END_W'(1);
      end
      DP_SHLOAD: begin
        chead_nxt = hd_head; lim_nxt = hd_end; pos_nxt = pos_r + HCNT_W'(1);
      end
      DP_STPROBE: tvalid_nxt = cur_w < TAIL_DEPTH;
      DP_SEMIT: begin
        wlo_nxt = sword[63:0]; whi_nxt = sword[127:64];
        if (cur_r != CUR_MAX) cur_nxt = cur_r + END_W'(1);
      end
      DP_OLOAD: ov_nxt = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      pos_r <= '0; cur_r <= '0; lim_r <= '0; chead_r <= '0;
    end else begin
      ov_r <= ov_nxt;
      pos_r <= pos_nxt; cur_r <= cur_nxt; lim_r <= lim_nxt; chead_r <= chead_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hi_r <= hi_nxt; hj_r <= hj_nxt; hk_r <= hk_nxt;
    ti_r <= ti_nxt; tj_r <= tj_nxt; tk_r <= tk_nxt; tvalid_r <= tvalid_nxt;
    found_r <= found_nxt; done_r <= done_nxt; wlo_r <= wlo_nxt; whi_r <= whi_nxt;
    if (cmd.op == DP_LATCH) begin
      op_r <= in_opcode;
      idx_r <= in_entry_index;
      hl_r <= in_head_letters;
      be_r <= in_block_end;
      key_r <= {in_word_low[7:0], in_word_low[15:8]};
      twr_r <= {in_word_high, in_word_low[63:16]};
      tkey_r <= tail_key({in_word_high, in_word_low[63:16]}, len2);
      skip_small_r <= in_skip_count < SKIP_W'(2);
    end
    if (cmd.op == DP_OLOAD) begin
      of_r <= found_r; olo_r <= wlo_r; ohi_r <= whi_r; od_r <= done_r;
    end
  end

  assign stat.opcode     = op_r;
  assign stat.h_live     = hi_r < hj_r;
  assign stat.h_eq       = key_r == hd_head;
  assign stat.k_zero     = hk_r == '0;
  assign stat.len2_zero  = len2 == '0;
  assign stat.t_live     = ti_r < tj_r;
  assign stat.t_eq       = tkey_r == t_key;
  assign stat.need_head  = cur_r >= lim_r;
  assign stat.heads_left = pos_r < eff_heads;
  assign stat.out_free   = !ov_r || out_ready;

  assign out_valid     = ov_r;
  assign out_found     = of_r;
  assign out_word_low  = olo_r;
  assign out_word_high = ohi_r;
  assign out_scan_done = od_r;
endmodule

>>> rtl/tlswl_ctrl.sv
`timescale 1ns / 1ps
module tlswl_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  tlswl_pkg::stat_t stat,
  output tlswl_pkg::cmd_t  cmd
);
  import tlswl_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_DEC   = 13'b0000000000010,
    S_HRD   = 13'b0000000000100,
    S_HCMP  = 13'b0000000001000,
    S_BRD   = 13'b0000000010000,
    S_BCMP  = 13'b0000000100000,
    S_TRD   = 13'b0000001000000,
    S_TCMP  = 13'b0000010000000,
    S_SHRD  = 13'b0000100000000,
    S_SHLD  = 13'b0001000000000,
    S_STRD  = 13'b0010000000000,
    S_STDAT = 13'b0100000000000,
    S_EMIT  = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd.op = DP_NONE;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = DP_LATCH;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        state_nxt = S_EMIT;
        unique case (stat.opcode)
          OP_WHEAD:  cmd.op = DP_WHEAD;
          OP_WTAIL:  cmd.op = DP_WTAIL;
          OP_LOOKUP: state_nxt = S_HRD;
          OP_START:  cmd.op = DP_START;
          OP_SKIP:   cmd.op = DP_SKIP;
          OP_NEXT: begin
            if (!stat.need_head) state_nxt = S_STRD;
            else if (stat.heads_left) state_nxt = S_SHRD;
            else cmd.op = DP_DONE;
          end
          default: ;
        endcase
      end
      S_HRD: begin
        if (stat.h_live) begin
          cmd.op = DP_HPROBE;
          state_nxt = S_HCMP;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_HCMP: begin
        priority if (!stat.h_eq) begin
          cmd.op = DP_HSTEP;
          state_nxt = S_HRD;
        end else if (stat.len2_zero) begin
          cmd.op = DP_FOUND;
          state_nxt = S_EMIT;
        end else begin
          cmd.op = DP_HHIT;
          state_nxt = stat.k_zero ? S_TRD : S_BRD;
        end
      end
      S_BRD: begin
        cmd.op = DP_BPROBE;
        state_nxt = S_BCMP;
      end
      S_BCMP: begin
        cmd.op = DP_BLOAD;
        state_nxt = S_TRD;
      end
      S_TRD: begin
        if (stat.t_live) begin
          cmd.op = DP_TPROBE;
          state_nxt = S_TCMP;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_TCMP: begin
        if (stat.t_eq) begin
          cmd.op = DP_FOUND;
          state_nxt = S_EMIT;
        end else begin
          cmd.op = DP_TSTEP;
          state_nxt = S_TRD;
        end
      end
      S_SHRD: begin
        cmd.op = DP_SHPROBE;
        state_nxt = S_SHLD;
      end
      S_SHLD: begin
        cmd.op = DP_SHLOAD;
        state_nxt = S_STRD;
      end
      S_STRD: begin
        cmd.op = DP_STPROBE;
        state_nxt = S_STDAT;
      end
      S_STDAT: begin
        cmd.op = DP_SEMIT;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.op = DP_OLOAD;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end
endmodule

>>> rtl/two_level_sorted_word_lookup.sv
`timescale 1ns / 1ps
// Dictionary of fixed-length words: a sorted head table of two-letter heads with
// cumulative block ends, and a tail store sorted within each head's block.
// in_ch carries one command beat: head write, tail write, lookup, scan start,
// scan next or scan skip. out_ch returns exactly one result beat per command.
// The APB port sets word_length (address 0) and head_count (address 4); write
// it only while no command is in flight.
// One command is processed at a time. A write, scan start or skip passes only
// through the decode and output states. Scan next takes longer when it must
// fetch the next head, and least once the scan is exhausted. A lookup does one
// read of the head or tail RAM for each head probe and each tail probe.
// A new command is taken while the previous result waits in the output
// register; if the receiver stalls, the next result waits until that register
// is taken, and input is held off meanwhile.
// Reset clears the registers, the scan position and the output valid; the
// RAMs are not cleared and must be written before they are read.
module two_level_sorted_word_lookup #(
  parameter int HEAD_DEPTH = tlswl_pkg::HEAD_DEPTH_DEF,
  parameter int TAIL_DEPTH = tlswl_pkg::TAIL_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  tlswl_in_if.sink    in_ch,
  tlswl_out_if.source out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tlswl_pkg::*;

  logic [LEN_W-1:0]  wl_r;
  logic [HCNT_W-1:0] hc_r;
  logic [LEN_W-1:0]  eff_len;
  logic [HCNT_W-1:0] eff_heads;
  logic              cfg_wr;
  cmd_t              cmd;
  stat_t             stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wl_r <= LEN_W'(2);
      hc_r <= '0;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_WORD_LENGTH) wl_r <= pwdata[LEN_W-1:0];
      else hc_r <= pwdata[HCNT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_HEAD_COUNT) ? 32'(hc_r) : 32'(wl_r);

  always_comb begin
    priority if (wl_r < LEN_W'(2)) eff_len = LEN_W'(2);
    else if (32'(wl_r) > MAX_WORD) eff_len = LEN_W'(MAX_WORD);
    else eff_len = wl_r;
    eff_heads = (32'(hc_r) > HEAD_DEPTH) ? HCNT_W'(HEAD_DEPTH) : hc_r;
  end

  tlswl_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .stat(stat), .cmd(cmd)
  );

  tlswl_dp #(.HEAD_DEPTH(HEAD_DEPTH), .TAIL_DEPTH(TAIL_DEPTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .eff_len(eff_len), .eff_heads(eff_heads),
    .in_opcode(in_ch.opcode), .in_entry_index(in_ch.entry_index),
    .in_head_letters(in_ch.head_letters), .in_block_end(in_ch.block_end),
    .in_word_low(in_ch.word_low), .in_word_high(in_ch.word_high),
    .in_skip_count(in_ch.skip_count),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_found(out_ch.found),
    .out_word_low(out_ch.out_word_low), .out_word_high(out_ch.out_word_high),
    .out_scan_done(out_ch.scan_done)
  );
endmodule

>>> rtl/tlswl_chk.sv
`timescale 1ns / 1ps
`include "two_level_sorted_word_lookup_macros.svh"
module tlswl_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        found,
  input logic [63:0] out_word_low,
  input logic [63:0] out_word_high,
  input logic        scan_done
);
  // Only one command is in flight, so an accepted beat closes the input.
  `TLSWL_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready, "input reopened")
  `TLSWL_ASSERT_SAME(a_found_not_done, clk, rst_n, out_valid && found, !scan_done, "found with done")
  `TLSWL_ASSERT_SAME(a_done_zero, clk, rst_n, out_valid && scan_done, (out_word_low == 64'd0) && (out_word_high == 64'd0), "done word nonzero")
  `TLSWL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_word_low) && $stable(found), "result dropped")
endmodule

bind two_level_sorted_word_lookup tlswl_chk u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .found(out_ch.found),
  .out_word_low(out_ch.out_word_low), .out_word_high(out_ch.out_word_high),
  .scan_done(out_ch.scan_done)
);

>>> test/tb_two_level_sorted_word_lookup.sv
`timescale 1ns / 1ps
module tb_two_level_sorted_word_lookup;
  import tlswl_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int LONG_HOLD   = 300;

  typedef struct packed {
    logic        found;
    logic [63:0] wlo;
    logic [63:0] whi;
    logic        done;
  } result_t;

  logic        clk;
  logic        rst_n;
  logic        psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;

  tlswl_in_if  in_ch ();
  tlswl_out_if out_ch ();

  two_level_sorted_word_lookup dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Predicted copy of the dictionary, registers and scan position.
  logic [LEN_W-1:0]  len_reg;
  logic [HCNT_W-1:0] hc_reg;
  logic [HEAD_W-1:0] head_mem [HEAD_DEPTH_DEF];
  logic [END_W-1:0]  end_mem [HEAD_DEPTH_DEF];
  logic [TAIL_W-1:0] tail_mem [TAIL_DEPTH_DEF];
  bit                tail_written [TAIL_DEPTH_DEF];
  int                scan_pos, scan_cur, scan_lim;
  logic [HEAD_W-1:0] scan_head;

  result_t     pending_results[$];
  result_t     last_res;
  logic [63:0] dict_lo[$], dict_hi[$];
  int          tail_span;
  bit          no_idle;
  int          hold_rx;
  int          idle_cycles;
  int          errors;
  int          n_lookup, n_hit, n_words, n_done, n_writes, n_cfg;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic int eff_len();
    int w;
    w = len_reg;
    if (w < 2) w = 2;
    if (w > MAX_WORD) w = MAX_WORD;
    return w;
  endfunction

  function automatic int eff_heads();
    return (hc_reg > HEAD_DEPTH_DEF) ? HEAD_DEPTH_DEF : int'(hc_reg);
  endfunction

  function automatic logic [7:0] word_byte(input logic [63:0] lo, input logic [63:0] hi,
                                           input int i);
    return (i < 8) ? lo[8*i +: 8] : hi[8*(i-8) +: 8];
  endfunction

  function automatic logic [7:0] tail_byte(input int idx, input int t);
    if (idx >= TAIL_DEPTH_DEF) return 8'h00;
    return tail_mem[idx][8*t +: 8];
  endfunction

  function automatic bit tail_less(input logic [TAIL_W-1:0] a, input logic [TAIL_W-1:0] b,
                                   input int len2);
    for (int t = 0; t < len2; t++) begin
      if (a[8*t +: 8] < b[8*t +: 8]) return 1'b1;
      if (a[8*t +: 8] > b[8*t +: 8]) return 1'b0;
    end
    return 1'b0;
  endfunction

  function automatic bit word_present(input logic [63:0] lo, input logic [63:0] hi);
    int i, j, k, len2, c;
    logic [15:0] key;
    logic [7:0] a, b;
    bit hit;
    i = 0;
    j = eff_heads();
    k = 0;
    hit = 1'b0;
    key = {lo[7:0], lo[15:8]};
    while (i < j && !hit) begin
      k = (i + j) / 2;
      if (key < head_mem[k]) j = k;
      else if (key > head_mem[k]) i = k + 1;
      else hit = 1'b1;
    end
    if (!hit) return 1'b0;
    len2 = eff_len() - 2;
    if (len2 == 0) return 1'b1;
    i = (k == 0) ? 0 : int'(end_mem[k-1]);
    j = end_mem[k];
    while (i < j) begin
      k = (i + j) / 2;
      c = 0;
      for (int t = 0; t < len2 && c == 0; t++) begin
        a = word_byte(lo, hi, t + 2);
        b = tail_byte(k, t);
        if (a < b) c = -1;
        else if (a > b) c = 1;
      end
      if (c < 0) j = k;
      else if (c > 0) i = k + 1;
      else return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic result_t next_result(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                                          input logic [HEAD_W-1:0] head,
                                          input logic [END_W-1:0] bend, input logic [63:0] lo,
                                          input logic [63:0] hi, input logic [SKIP_W-1:0] skip);
    result_t r;
    int len;
    r = '0;
    len = eff_len();
    case (op)
      OP_WHEAD: begin
        n_writes++;
        if (idx < HEAD_DEPTH_DEF) begin
          head_mem[idx] = head;
          end_mem[idx] = bend;
        end
      end
      OP_WTAIL: begin
        n_writes++;
        tail_mem[idx] = {hi, lo[63:16]};
        tail_written[idx] = 1'b1;
      end
      OP_LOOKUP: begin
        r.found = word_present(lo, hi);
        n_lookup++;
        if (r.found) n_hit++;
      end
      OP_START: begin
        scan_pos = 0;
        scan_cur = 0;
        scan_lim = 0;
        scan_head = '0;
      end
      OP_NEXT: begin
        if (scan_cur >= scan_lim) begin
          if (scan_pos >= eff_heads()) begin
            r.done = 1'b1;
            n_done++;
            return r;
          end
          scan_head = head_mem[scan_pos];
          scan_lim = end_mem[scan_pos];
          scan_pos++;
        end
        r.wlo[7:0] = scan_head[15:8];
        r.wlo[15:8] = scan_head[7:0];
        for (int t = 2; t < len; t++) begin
          if (t < 8) r.wlo[8*t +: 8] = tail_byte(scan_cur, t - 2);
          else r.whi[8*(t-8) +: 8] = tail_byte(scan_cur, t - 2);
        end
        if (scan_cur < 8191) scan_cur++;
        n_words++;
      end
      OP_SKIP: if (skip < 2) scan_cur = scan_lim;
      default: ;
    endcase
    return r;
  endfunction

  // A scan next must not fetch a tail entry that was never loaded.
  function automatic bit next_is_safe();
    if (eff_len() == 2) return 1'b1;
    if (scan_cur >= scan_lim && scan_pos >= eff_heads()) return 1'b1;
    if (scan_cur >= TAIL_DEPTH_DEF) return 1'b1;
    return tail_written[scan_cur];
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [TAIL_W-1:0] rand_tail();
    logic [TAIL_W-1:0] tv;
    for (int b = 0; b < TAIL_BYTES; b++)
      tv[8*b +: 8] = ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom);
    return tv;
  endfunction

  task automatic send(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                      input logic [HEAD_W-1:0] head, input logic [END_W-1:0] bend,
                      input logic [63:0] lo, input logic [63:0] hi,
                      input logic [SKIP_W-1:0] skip);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    repeat (gap) @(negedge clk);
    in_ch.opcode = op;
    in_ch.entry_index = idx;
    in_ch.head_letters = head;
    in_ch.block_end = bend;
    in_ch.word_low = lo;
    in_ch.word_high = hi;
    in_ch.skip_count = skip;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    last_res = next_result(op, idx, head, bend, lo, hi, skip);
    pending_results.push_back(last_res);
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  // Fields that the opcode does not use carry random values.
  task automatic send_op(input logic [OP_W-1:0] op);
    send(op, IDX_W'($urandom), HEAD_W'($urandom), END_W'($urandom), rand64(), rand64(),
         SKIP_W'($urandom_range(0, 16)));
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic cfg_write(input logic sel, input logic [31:0] val);
    drain();
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {sel, 2'b00};
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (sel == REG_WORD_LENGTH) len_reg = val[LEN_W-1:0];
    else hc_reg = val[HCNT_W-1:0];
    n_cfg++;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Loads n sorted heads with sorted tail blocks, plus a few spare tails past
  // the last block so that scans running over empty blocks stay on loaded data.
  task automatic load_dict(input int n, input int maxblk, input bit sparse);
    int step, total, sz, pos, len2, m;
    logic [HEAD_W-1:0] heads[$];
    logic [END_W-1:0] ends[$];
    logic [TAIL_W-1:0] blk[$], all_tails[$];
    logic [TAIL_W-1:0] tv;
    logic [HEAD_W-1:0] h;
    len2 = eff_len() - 2;
    step = 65536 / n;
    total = 0;
    dict_lo.delete();
    dict_hi.delete();
    for (int i = 0; i < n; i++) begin
      h = HEAD_W'(i * step + $urandom_range(0, step - 1));
      if (i == 0 && $urandom_range(0, 1)) h = '0;
      if (i == n - 1 && $urandom_range(0, 1)) h = '1;
      sz = (len2 == 0 || (sparse && $urandom_range(0, 7) != 0)) ? 0 :
           $urandom_range(0, maxblk);
      blk.delete();
      for (int s = 0; s < sz; s++) begin
        tv = rand_tail();
        pos = blk.size();
        while (pos > 0 && tail_less(tv, blk[pos-1], len2)) pos--;
        blk.insert(pos, tv);
      end
      foreach (blk[s]) begin
        all_tails.push_back(blk[s]);
        dict_lo.push_back({blk[s][47:0], h[7:0], h[15:8]});
        dict_hi.push_back(blk[s][111:48]);
      end
      if (len2 == 0) begin
        dict_lo.push_back({48'(rand64() >> 16), h[7:0], h[15:8]});
        dict_hi.push_back(rand64());
      end
      total += sz;
      heads.push_back(h);
      ends.push_back(END_W'(total));
    end
    // An inverted block: its end lies before its start.
    if (n > 2 && $urandom_range(0, 1)) begin
      m = $urandom_range(1, n - 1);
      if (ends[m-1] > 0) ends[m] = ends[m-1] - 1'b1;
    end
    repeat (6) all_tails.push_back(rand_tail());
    tail_span = all_tails.size();
    foreach (all_tails[i])
      send(OP_WTAIL, IDX_W'(i), HEAD_W'($urandom), END_W'($urandom),
           {all_tails[i][47:0], 16'($urandom)}, all_tails[i][111:48],
           SKIP_W'($urandom_range(0, 16)));
    foreach (heads[i])
      send(OP_WHEAD, IDX_W'(i), heads[i], ends[i], rand64(), rand64(),
           SKIP_W'($urandom_range(0, 16)));
  endtask

  task automatic do_lookup();
    int v, len, bi, w;
    logic [63:0] lo, hi;
    logic [7:0] delta;
    v = $urandom_range(0, 9);
    len = eff_len();
    lo = rand64();
    hi = rand64();
    if (dict_lo.size() != 0 && v < 8) begin
      w = $urandom_range(0, dict_lo.size() - 1);
      lo = dict_lo[w];
      hi = dict_hi[w];
      if (v >= 5 && v < 7) begin
        bi = $urandom_range(0, len - 1);
        delta = 8'($urandom_range(1, 255));
        if (bi < 8) lo[8*bi +: 8] ^= delta;
        else hi[8*(bi-8) +: 8] ^= delta;
      end else if (v == 7) begin
        lo[63:16] = 48'(rand64() >> 16);
        hi = rand64();
      end
    end
    send(OP_LOOKUP, IDX_W'($urandom), HEAD_W'($urandom), END_W'($urandom), lo, hi,
         SKIP_W'($urandom_range(0, 16)));
  endtask

  task automatic scan_step();
    if (next_is_safe()) send_op(OP_NEXT);
    else send_op(OP_START);
  endtask

  task automatic scan_walk();
    send_op(OP_START);
    for (int s = 0; s < 400; s++) begin
      if (!next_is_safe()) break;
      send_op(OP_NEXT);
      if (last_res.done) break;
    end
  endtask

  task automatic run_traffic(input int n);
    int roll;
    for (int k = 0; k < n; k++) begin
      if (k % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
        do_lookup();
      end else if (roll < 72) begin
        if ($urandom_range(0, 9) == 0) send_op(OP_SKIP);
        else scan_step();
      end else if (roll < 80) begin
        if (tail_span > 0 && $urandom_range(0, 3) != 0)
          send(OP_WTAIL, IDX_W'($urandom_range(0, tail_span - 1)), HEAD_W'($urandom),
               END_W'($urandom), rand64(), rand64(), SKIP_W'($urandom_range(0, 16)));
        else
          send_op(OP_WTAIL);
      end else if (roll < 88) begin
        if (eff_heads() > 0 && $urandom_range(0, 1))
          send(OP_WHEAD, IDX_W'($urandom_range(0, eff_heads() - 1)), HEAD_W'($urandom),
               END_W'($urandom_range(0, tail_span)), rand64(), rand64(),
               SKIP_W'($urandom_range(0, 16)));
        else
          send(OP_WHEAD, IDX_W'($urandom_range(HEAD_DEPTH_DEF, 4095)), HEAD_W'($urandom),
               END_W'($urandom_range(0, 4096)), rand64(), rand64(),
               SKIP_W'($urandom_range(0, 16)));
      end else if (roll < 94) begin
        send_op(OP_W'($urandom_range(6, 7)));
      end else begin
        send_op(OP_START);
      end
    end
    no_idle = 1'b0;
  endtask

  task automatic test_reset_state();
    do_lookup();
    send_op(OP_NEXT);
    send_op(OP_START);
    send_op(OP_SKIP);
    send_op(OP_NEXT);
    send_op(OP_W'(6));
    send_op(OP_W'(7));
    send(OP_WHEAD, 12'hFFF, 16'hFFFF, 13'd4096, '1, '1, 5'd16);
    cfg_write(REG_WORD_LENGTH, 32'd0);
    cfg_write(REG_HEAD_COUNT, 32'd0);
    do_lookup();
    send_op(OP_NEXT);
  endtask

  task automatic test_two_letter_words();
    cfg_write(REG_WORD_LENGTH, 32'd1);
    cfg_write(REG_HEAD_COUNT, 32'd12);
    load_dict(12, 0, 1'b0);
    repeat (10) do_lookup();
    scan_walk();
    cfg_write(REG_WORD_LENGTH, 32'd2);
    repeat (4) do_lookup();
  endtask

  task automatic test_full_length_words();
    logic [63:0] hi;
    cfg_write(REG_WORD_LENGTH, 32'd16);
    cfg_write(REG_HEAD_COUNT, 32'd8);
    load_dict(8, 3, 1'b0);
    if (dict_lo.size() != 0) begin
      send(OP_LOOKUP, '0, '0, '0, dict_lo[0], dict_hi[0], '0);
      send(OP_LOOKUP, '1, '1, '1, dict_lo[$], dict_hi[$], 5'd16);
      // Only the last letter differs.
      hi = dict_hi[$] ^ 64'hFF00_0000_0000_0000;
      send(OP_LOOKUP, '0, '0, '0, dict_lo[$], hi, '0);
    end
    send(OP_LOOKUP, '0, '0, '0, '0, '0, '0);
    send(OP_LOOKUP, '0, '0, '0, '1, '1, '0);
    send_op(OP_START);
    repeat (3) scan_step();
    send(OP_SKIP, '0, '0, '0, '0, '0, 5'd1);
    scan_step();
    send(OP_SKIP, '0, '0, '0, '0, '0, 5'd16);
    scan_step();
    send(OP_SKIP, '0, '0, '0, '0, '0, 5'd0);
    scan_step();
    send(OP_SKIP, '0, '0, '0, '0, '0, 5'd2);
    send(OP_WHEAD, IDX_W'(HEAD_DEPTH_DEF), 16'h0000, 13'd4096, '0, '0, '0);
    send_op(OP_W'(6));
    send_op(OP_W'(7));
    scan_walk();
  endtask

  task automatic test_random_lengths();
    int lens[4];
    int hc;
    lens = '{31, 3, $urandom_range(4, 15), 16};
    foreach (lens[p]) begin
      hc = $urandom_range(2, 5);
      cfg_write(REG_WORD_LENGTH, 32'(lens[p]));
      cfg_write(REG_HEAD_COUNT, 32'(hc));
      load_dict(hc, 2, 1'b0);
      run_traffic(6);
    end
  endtask

  task automatic test_full_head_table();
    cfg_write(REG_WORD_LENGTH, 32'd5);
    cfg_write(REG_HEAD_COUNT, 32'd1023);
    load_dict(HEAD_DEPTH_DEF, 1, 1'b1);
    run_traffic(16);
    cfg_write(REG_HEAD_COUNT, 32'(HEAD_DEPTH_DEF));
    run_traffic(8);
  endtask

  // The receiver holds off while lookups keep coming, so the block fills and
  // stalls its input; then the sender waits for every result.
  task automatic test_backpressure();
    no_idle = 1'b1;
    hold_rx = LONG_HOLD;
    repeat (12) do_lookup();
    no_idle = 1'b0;
    drain();
    repeat (6) do_lookup();
  endtask

  task automatic test_empty_table();
    cfg_write(REG_HEAD_COUNT, 32'd0);
    do_lookup();
    send_op(OP_START);
    send_op(OP_NEXT);
    send_op(OP_NEXT);
  endtask

  // Result receiver with a random stall before each beat.
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (hold_rx > 0) begin
        out_ch.ready = 1'b0;
        repeat (hold_rx) @(negedge clk);
        hold_rx = 0;
      end
      gap = no_idle ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        out_ch.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid && hold_rx == 0);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    result_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with nothing expected", $time);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_ch.found !== e.found) begin
          $display("%0t: found expected %b got %b", $time, e.found, out_ch.found);
          errors++;
        end
        if (out_ch.out_word_low !== e.wlo) begin
          $display("%0t: out_word_low expected %h got %h", $time, e.wlo, out_ch.out_word_low);
          errors++;
        end
        if (out_ch.out_word_high !== e.whi) begin
          $display("%0t: out_word_high expected %h got %h", $time, e.whi,
                   out_ch.out_word_high);
          errors++;
        end
        if (out_ch.scan_done !== e.done) begin
          $display("%0t: scan_done expected %b got %b", $time, e.done, out_ch.scan_done);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("** two_level_sorted_word_lookup: FAILED **");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_WHEAD;
    in_ch.entry_index = '0;
    in_ch.head_letters = '0;
    in_ch.block_end = '0;
    in_ch.word_low = '0;
    in_ch.word_high = '0;
    in_ch.skip_count = '0;
    len_reg = 5'd2;
    hc_reg = '0;
    scan_pos = 0;
    scan_cur = 0;
    scan_lim = 0;
    scan_head = '0;
    tail_span = 0;
    no_idle = 1'b0;
    hold_rx = 0;
    idle_cycles = 0;
    errors = 0;
    n_lookup = 0;
    n_hit = 0;
    n_words = 0;
    n_done = 0;
    n_writes = 0;
    n_cfg = 0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_reset_state();
    test_two_letter_words();
    test_full_length_words();
    test_random_lengths();
    test_backpressure();
    test_full_head_table();
    test_empty_table();

    drain();
    repeat (60) @(posedge clk);
    $display("Ran %0d lookups (%0d found), %0d scanned words, %0d scan ends,", n_lookup,
             n_hit, n_words, n_done);
    $display("%0d table writes and %0d register writes; %0d mismatches.", n_writes, n_cfg,
             errors);
    if (errors == 0) begin
      $display("** two_level_sorted_word_lookup: PASSED **");
    end else begin
      $display("** two_level_sorted_word_lookup: FAILED **");
    end
    $finish;
  end
endmodule
